// File: rtl/sparse_polynomial_adder_core_macros.svh
// Assertion macros used by the sparse polynomial adder port checker.
`ifndef SPARSE_POLYNOMIAL_ADDER_CORE_MACROS_SVH
`define SPARSE_POLYNOMIAL_ADDER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SPA_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sparse polynomial adder assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SPA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sparse polynomial adder assertion failed");

`endif

// File: rtl/spa_pkg.sv
// Package with beat types, codes and defaults for the sparse polynomial adder.
package spa_pkg;

   // Defaults for the top-level parameters.
   localparam int MAX_TERMS_DEF  = 32;
   localparam int COEFF_BITS_DEF = 32;

   // Fixed field widths of the beats.
   localparam int EXP_BITS      = 16;
   localparam int OUT_COEFF_BITS = 32;

   // Request codes.
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_ADD  = 1'b1;

   // Store selector codes.
   localparam logic POLY_FIRST  = 1'b0;
   localparam logic POLY_SECOND = 1'b1;

   // Request beat.
   typedef struct packed {
      logic                        req_type;
      logic                        which_poly;
      logic signed [31:0]          term_coeff;
      logic [EXP_BITS-1:0]         term_exponent;
   } req_beat_type;

   // Result beat.
   typedef struct packed {
      logic signed [OUT_COEFF_BITS-1:0] out_coeff;
      logic [EXP_BITS-1:0]              out_exponent;
      logic                             last_term;
      logic                             result_empty;
      logic                             overflowed;
   } rsp_beat_type;

   // Status flags from the shared arithmetic unit.
   typedef struct packed {
      logic gt;     // exponent a above exponent b
      logic eq;     // exponents equal
      logic zero;   // coefficient sum is zero
   } alu_flags_type;

endpackage

// File: rtl/sparse_polynomial_adder_core.sv
// Top level of the sparse polynomial adder: sequencer, term stores and result register.
//
//   Channel | Ports                        | Direction | Beat
//   req     | req_valid req_ready req_data | in        | load one term, or add both stores
//   rsp     | rsp_valid rsp_ready rsp_data | out       | one result term, or the empty marker
//
// An inserting load runs a linear search that reads one entry per cycle, then the tail moves
// up one entry per cycle; a load that combines or is dropped ends where the search stops.
// An add merges the store heads in descending exponent order, adding a pair of equal
// exponents into one term and dropping a zero sum; a full result register can hold the
// merge back.
// Reset clears counts, overflow flag and handshakes, not the stores; req_ready is high in idle.
module sparse_polynomial_adder_core #(
   parameter int MAX_TERMS  = spa_pkg::MAX_TERMS_DEF,
   parameter int COEFF_BITS = spa_pkg::COEFF_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  spa_pkg::req_beat_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output spa_pkg::rsp_beat_type rsp_data
);

   localparam int AW = $clog2(MAX_TERMS);
   localparam int CW = $clog2(MAX_TERMS + 1);
   localparam int EW = spa_pkg::EXP_BITS;
   localparam int TW = COEFF_BITS + EW;
   localparam int OW = spa_pkg::OUT_COEFF_BITS;

   localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_TERMS);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SEARCH = 3'd1;
   localparam logic [2:0] ST_SHIFT  = 3'd2;
   localparam logic [2:0] ST_MERGE  = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic                  sel_ff, sel_in;
   logic [COEFF_BITS-1:0] coeff_ff, coeff_in;
   logic [EW-1:0]         expo_ff, expo_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [AW-1:0]         sh_ff, sh_in;
   logic [CW-1:0]         cnt1_ff, cnt1_in;
   logic [CW-1:0]         cnt2_ff, cnt2_in;
   logic                  ovf_ff, ovf_in;
   logic [CW-1:0]         i_ff, i_in;
   logic [CW-1:0]         j_ff, j_in;
   logic                  pend_v_ff, pend_v_in;
   logic [COEFF_BITS-1:0] pend_coeff_ff, pend_coeff_in;
   logic [EW-1:0]         pend_expo_ff, pend_expo_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   spa_pkg::rsp_beat_type rsp_ff, rsp_in;

   // Memory ports.
   logic                  wr1_en, wr2_en, wr_en;
   logic [AW-1:0]         wr_addr;
   logic [TW-1:0]         wr_data;
   logic [AW-1:0]         rd1_addr, rd2_addr, rd_addr_load;
   logic [TW-1:0]         rd1_data, rd2_data;

   // Split read data.
   logic [COEFF_BITS-1:0] rd1_coeff, rd2_coeff, rds_coeff;
   logic [EW-1:0]         rd1_expo, rd2_expo, rds_expo;
   logic [CW-1:0]         sel_count;

   // Shared unit ports.
   logic [COEFF_BITS-1:0] alu_a_coeff, alu_b_coeff, alu_sum;
   logic [EW-1:0]         alu_a_expo, alu_b_expo;
   spa_pkg::alu_flags_type alu_flags;

   // Merge decision.
   logic                  has1, has2, prod, take1, take2, stall, rsp_free;
   logic [COEFF_BITS-1:0] prod_coeff;
   logic [EW-1:0]         prod_expo;

   assign rd1_coeff = rd1_data[TW-1:EW];
   assign rd1_expo  = rd1_data[EW-1:0];
   assign rd2_coeff = rd2_data[TW-1:EW];
   assign rd2_expo  = rd2_data[EW-1:0];
   assign rds_coeff = (sel_ff == spa_pkg::POLY_SECOND) ? rd2_coeff : rd1_coeff;
   assign rds_expo  = (sel_ff == spa_pkg::POLY_SECOND) ? rd2_expo  : rd1_expo;
   assign sel_count = (sel_ff == spa_pkg::POLY_SECOND) ? cnt2_ff   : cnt1_ff;

   // The shared unit compares two store heads during a merge, else a stored entry
   // against the term being loaded.
   always_comb begin
      if (state_ff == ST_MERGE) begin
         alu_a_coeff = rd1_coeff;
         alu_a_expo  = rd1_expo;
         alu_b_coeff = rd2_coeff;
         alu_b_expo  = rd2_expo;
      end else begin
         alu_a_coeff = rds_coeff;
         alu_a_expo  = rds_expo;
         alu_b_coeff = coeff_ff;
         alu_b_expo  = expo_ff;
      end
   end

   spa_alu #(
      .COEFF_BITS (COEFF_BITS)
   ) u_spa_alu (
      .a_coeff (alu_a_coeff),
      .a_expo  (alu_a_expo),
      .b_coeff (alu_b_coeff),
      .b_expo  (alu_b_expo),
      .sum     (alu_sum),
      .flags   (alu_flags)
   );

   // Merge step: which store heads are retired and what term comes out.
   always_comb begin
      has1       = (i_ff < cnt1_ff);
      has2       = (j_ff < cnt2_ff);
      take1      = 1'b0;
      take2      = 1'b0;
      prod       = 1'b0;
      prod_coeff = rd1_coeff;
      prod_expo  = rd1_expo;
      if (has1 && has2 && alu_flags.eq) begin
         take1      = 1'b1;
         take2      = 1'b1;
         prod       = !alu_flags.zero;
         prod_coeff = alu_sum;
      end else if (has1 && (!has2 || alu_flags.gt)) begin
         take1 = 1'b1;
         prod  = 1'b1;
      end else if (has2) begin
         take2      = 1'b1;
         prod       = 1'b1;
         prod_coeff = rd2_coeff;
         prod_expo  = rd2_expo;
      end
   end

   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign stall    = prod && pend_v_ff && !rsp_free;

   // Sequencer next-state logic.
   always_comb begin
      state_in      = state_ff;
      sel_in        = sel_ff;
      coeff_in      = coeff_ff;
      expo_in       = expo_ff;
      idx_in        = idx_ff;
      sh_in         = sh_ff;
      cnt1_in       = cnt1_ff;
      cnt2_in       = cnt2_ff;
      ovf_in        = ovf_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      pend_v_in     = pend_v_ff;
      pend_coeff_in = pend_coeff_ff;
      pend_expo_in  = pend_expo_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff[AW-1:0];
      wr_data       = {coeff_ff, expo_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sel_in   = req_data.which_poly;
               coeff_in = req_data.term_coeff[COEFF_BITS-1:0];
               expo_in  = req_data.term_exponent;
               idx_in   = '0;
               i_in     = '0;
               j_in     = '0;
               if (req_data.req_type == spa_pkg::REQ_ADD) begin
                  pend_v_in = 1'b0;
                  state_in  = ST_MERGE;
               end else begin
                  state_in = ST_SEARCH;
               end
            end
         end

         // Walk the store from the top until an exponent not above the new one.
         ST_SEARCH: begin
            if ((idx_ff < sel_count) && alu_flags.gt) begin
               idx_in = CW'(idx_ff + 1'b1);
            end else if ((idx_ff < sel_count) && alu_flags.eq) begin
               wr_en    = 1'b1;
               wr_data  = {alu_sum, rds_expo};
               state_in = ST_IDLE;
            end else if (sel_count == FULL_COUNT) begin
               ovf_in   = 1'b1;
               state_in = ST_IDLE;
            end else begin
               sh_in    = sel_count[AW-1:0];
               state_in = ST_SHIFT;
            end
         end

         // Move the tail up one entry per cycle, then drop the new term in the gap.
         ST_SHIFT: begin
            wr_en = 1'b1;
            if (CW'(sh_ff) == idx_ff) begin
               wr_addr  = sh_ff;
               wr_data  = {coeff_ff, expo_ff};
               state_in = ST_IDLE;
               if (sel_ff == spa_pkg::POLY_SECOND) begin
                  cnt2_in = CW'(cnt2_ff + 1'b1);
               end else begin
                  cnt1_in = CW'(cnt1_ff + 1'b1);
               end
            end else begin
               wr_addr = sh_ff;
               wr_data = {rds_coeff, rds_expo};
               sh_in   = AW'(sh_ff - 1'b1);
            end
         end

         // One term per cycle unless stalled; the newest is held back to mark the last.
         ST_MERGE: begin
            if (!has1 && !has2) begin
               state_in = ST_FINISH;
            end else if (!stall) begin
               if (take1) begin
                  i_in = CW'(i_ff + 1'b1);
               end
               if (take2) begin
                  j_in = CW'(j_ff + 1'b1);
               end
               if (prod) begin
                  if (pend_v_ff) begin
                     rsp_valid_in        = 1'b1;
                     rsp_in.out_coeff    = OW'($signed(pend_coeff_ff));
                     rsp_in.out_exponent = pend_expo_ff;
                     rsp_in.last_term    = 1'b0;
                     rsp_in.result_empty = 1'b0;
                     rsp_in.overflowed   = ovf_ff;
                  end
                  pend_v_in     = 1'b1;
                  pend_coeff_in = prod_coeff;
                  pend_expo_in  = prod_expo;
               end
            end
         end

         // Emit the held term as the last one, or the empty marker, and clear the stores.
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.last_term    = 1'b1;
               rsp_in.overflowed   = ovf_ff;
               rsp_in.result_empty = !pend_v_ff;
               if (pend_v_ff) begin
                  rsp_in.out_coeff    = OW'($signed(pend_coeff_ff));
                  rsp_in.out_exponent = pend_expo_ff;
               end else begin
                  rsp_in.out_coeff    = '0;
                  rsp_in.out_exponent = '0;
               end
               pend_v_in = 1'b0;
               cnt1_in   = '0;
               cnt2_in   = '0;
               state_in  = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Read addresses follow the next index so the registered data lines up with it.
   always_comb begin
      if (state_in == ST_SHIFT) begin
         rd_addr_load = AW'(sh_in - 1'b1);
      end else begin
         rd_addr_load = idx_in[AW-1:0];
      end
      if (state_in == ST_MERGE) begin
         rd1_addr = i_in[AW-1:0];
         rd2_addr = j_in[AW-1:0];
      end else begin
         rd1_addr = rd_addr_load;
         rd2_addr = rd_addr_load;
      end
   end

   assign wr1_en = wr_en && (sel_ff == spa_pkg::POLY_FIRST);
   assign wr2_en = wr_en && (sel_ff == spa_pkg::POLY_SECOND);

   spa_term_mem #(
      .DEPTH (MAX_TERMS),
      .WIDTH (TW)
   ) u_first_terms (
      .clock   (clock),
      .wr_en   (wr1_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd1_addr),
      .rd_data (rd1_data)
   );

   spa_term_mem #(
      .DEPTH (MAX_TERMS),
      .WIDTH (TW)
   ) u_second_terms (
      .clock   (clock),
      .wr_en   (wr2_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd2_addr),
      .rd_data (rd2_data)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt1_ff      <= '0;
         cnt2_ff      <= '0;
         ovf_ff       <= 1'b0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt1_ff      <= cnt1_in;
         cnt2_ff      <= cnt2_in;
         ovf_ff       <= ovf_in;
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and index registers.
   always_ff @(posedge clock) begin
      sel_ff        <= sel_in;
      coeff_ff      <= coeff_in;
      expo_ff       <= expo_in;
      idx_ff        <= idx_in;
      sh_ff         <= sh_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      pend_coeff_ff <= pend_coeff_in;
      pend_expo_ff  <= pend_expo_in;
      rsp_ff        <= rsp_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: rtl/spa_alu.sv
// Shared arithmetic unit: coefficient add with wrap and exponent compare.
module spa_alu #(
   parameter int COEFF_BITS = spa_pkg::COEFF_BITS_DEF
) (
   input  logic [COEFF_BITS-1:0]        a_coeff,
   input  logic [spa_pkg::EXP_BITS-1:0] a_expo,
   input  logic [COEFF_BITS-1:0]        b_coeff,
   input  logic [spa_pkg::EXP_BITS-1:0] b_expo,
   output logic [COEFF_BITS-1:0]        sum,
   output spa_pkg::alu_flags_type       flags
);

   // The sum wraps in the coefficient width.
   assign sum = a_coeff + b_coeff;

   // Exponent ordering and zero detect for the sequencer.
   always_comb begin
      flags.gt   = (a_expo > b_expo);
      flags.eq   = (a_expo == b_expo);
      flags.zero = (sum == '0);
   end

endmodule

// File: rtl/spa_term_mem.sv
// Term store memory: one write port and one registered read port.
module spa_term_mem #(
   parameter int DEPTH = spa_pkg::MAX_TERMS_DEF,
   parameter int WIDTH = spa_pkg::COEFF_BITS_DEF + spa_pkg::EXP_BITS
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port; a read at the address being written sees the old entry.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/spa_checker.sv
// Port-level checker for the sparse polynomial adder and its bind.
`include "sparse_polynomial_adder_core_macros.svh"

module spa_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input spa_pkg::req_beat_type req_data,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input spa_pkg::rsp_beat_type rsp_data
);

   // A stalled result beat holds.
   `SPA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // The empty marker is the last beat and carries no term.
   `SPA_ASSERT_IMPLY(a_empty_marker, clock, reset, rsp_valid && rsp_data.result_empty, rsp_data.last_term && (rsp_data.out_coeff == '0) && (rsp_data.out_exponent == '0))

   // An accepted add keeps the block busy in the next cycle.
   `SPA_ASSERT_NEXT(a_add_busy, clock, reset, req_valid && req_ready && (req_data.req_type == spa_pkg::REQ_ADD), !req_ready)

   // While a result is still incomplete no new request is taken.
   `SPA_ASSERT_IMPLY(a_busy_mid_result, clock, reset, rsp_valid && !rsp_data.last_term, !req_ready)

endmodule

bind sparse_polynomial_adder_core spa_checker u_spa_checker (.*);

// File: tb/sparse_polynomial_adder_checker.sv
// Checker that predicts the result beats of the sparse polynomial adder and compares them.
module sparse_polynomial_adder_checker #(
   parameter int MAX_TERMS  = spa_pkg::MAX_TERMS_DEF,
   parameter int COEFF_BITS = spa_pkg::COEFF_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  spa_pkg::req_beat_type req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  spa_pkg::rsp_beat_type rsp_data,
   output int                    outstanding,
   output int                    mismatches
);
   timeunit 1ns;
   timeprecision 1ps;

   // One stored term at the block's coefficient width.
   typedef struct packed {
      logic [COEFF_BITS-1:0]        coeff;
      logic [spa_pkg::EXP_BITS-1:0] expo;
   } poly_term_type;

   poly_term_type         store_terms [2][MAX_TERMS];
   int                    store_count [2];
   logic                  overflow_seen;
   spa_pkg::rsp_beat_type sum_terms_q [$];
   int                    mismatch_total;

   // Builds one result beat; the coefficient is sign-extended to the beat width.
   function automatic spa_pkg::rsp_beat_type make_beat(
      input logic [COEFF_BITS-1:0]        coeff,
      input logic [spa_pkg::EXP_BITS-1:0] expo,
      input logic                         empty);
      spa_pkg::rsp_beat_type beat;
      beat.out_coeff    = spa_pkg::OUT_COEFF_BITS'($signed(coeff));
      beat.out_exponent = expo;
      beat.last_term    = empty;
      beat.result_empty = empty;
      beat.overflowed   = overflow_seen;
      return beat;
   endfunction

   // Sorted insertion into one store: combine on an equal exponent, drop when full.
   task automatic insert_term(input logic sel, input logic [COEFF_BITS-1:0] coeff,
                              input logic [spa_pkg::EXP_BITS-1:0] expo);
      int n;
      int pos;
      int i;
      n = store_count[sel];
      pos = 0;
      while (pos < n && store_terms[sel][pos].expo > expo) pos++;
      if (pos < n && store_terms[sel][pos].expo == expo) begin
         store_terms[sel][pos].coeff = store_terms[sel][pos].coeff + coeff;
      end else if (n >= MAX_TERMS) begin
         overflow_seen = 1'b1;
      end else begin
         for (i = n; i > pos; i--) store_terms[sel][i] = store_terms[sel][i - 1];
         store_terms[sel][pos].coeff = coeff;
         store_terms[sel][pos].expo  = expo;
         store_count[sel] = n + 1;
      end
   endtask

   // Merges both stores in descending exponent order and queues the sum terms.
   task automatic merge_stores();
      int                    i;
      int                    j;
      int                    n1;
      int                    n2;
      int                    nr;
      logic [COEFF_BITS-1:0] s;
      poly_term_type         ta;
      poly_term_type         tb;
      i = 0;
      j = 0;
      nr = 0;
      n1 = store_count[spa_pkg::POLY_FIRST];
      n2 = store_count[spa_pkg::POLY_SECOND];
      while (i < n1 || j < n2) begin
         if (i < n1) ta = store_terms[spa_pkg::POLY_FIRST][i];
         if (j < n2) tb = store_terms[spa_pkg::POLY_SECOND][j];
         if (i < n1 && j < n2 && ta.expo == tb.expo) begin
            // Equal exponents add; a zero sum vanishes from the result.
            s = ta.coeff + tb.coeff;
            if (s != '0) begin
               sum_terms_q.push_back(make_beat(s, ta.expo, 1'b0));
               nr++;
            end
            i++;
            j++;
         end else if (j >= n2 || (i < n1 && ta.expo > tb.expo)) begin
            sum_terms_q.push_back(make_beat(ta.coeff, ta.expo, 1'b0));
            nr++;
            i++;
         end else begin
            sum_terms_q.push_back(make_beat(tb.coeff, tb.expo, 1'b0));
            nr++;
            j++;
         end
      end
      store_count[spa_pkg::POLY_FIRST]  = 0;
      store_count[spa_pkg::POLY_SECOND] = 0;
      if (nr == 0) begin
         sum_terms_q.push_back(make_beat('0, '0, 1'b1));
      end else begin
         sum_terms_q[sum_terms_q.size() - 1].last_term = 1'b1;
      end
   endtask

   // Compare accepted result beats, then update the prediction for an accepted request.
   always @(posedge clock) begin
      spa_pkg::rsp_beat_type want;
      if (reset) begin
         store_count[spa_pkg::POLY_FIRST]  = 0;
         store_count[spa_pkg::POLY_SECOND] = 0;
         overflow_seen = 1'b0;
         sum_terms_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (sum_terms_q.size() == 0) begin
               $display("%0t: unexpected result beat: expected none,", $time,
                        " actual coeff=%h exp=%h last=%b empty=%b ovf=%b",
                        rsp_data.out_coeff, rsp_data.out_exponent, rsp_data.last_term,
                        rsp_data.result_empty, rsp_data.overflowed);
               mismatch_total++;
            end else begin
               want = sum_terms_q.pop_front();
               if (rsp_data.out_coeff !== want.out_coeff ||
                   rsp_data.out_exponent !== want.out_exponent ||
                   rsp_data.last_term !== want.last_term ||
                   rsp_data.result_empty !== want.result_empty ||
                   rsp_data.overflowed !== want.overflowed) begin
                  $display("%0t: result beat differs:", $time,
                           " expected coeff=%h exp=%h last=%b empty=%b ovf=%b,",
                           want.out_coeff, want.out_exponent, want.last_term,
                           want.result_empty, want.overflowed,
                           " actual coeff=%h exp=%h last=%b empty=%b ovf=%b",
                           rsp_data.out_coeff, rsp_data.out_exponent, rsp_data.last_term,
                           rsp_data.result_empty, rsp_data.overflowed);
                  mismatch_total++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_data.req_type == spa_pkg::REQ_LOAD) begin
               insert_term(req_data.which_poly, req_data.term_coeff[COEFF_BITS-1:0],
                           req_data.term_exponent);
            end else begin
               merge_stores();
            end
         end
      end
      outstanding <= sum_terms_q.size();
      mismatches  <= mismatch_total;
   end

endmodule

// File: tb/tb_sparse_polynomial_adder_core.sv
// Testbench top for the sparse polynomial adder: stimulus, back-pressure and verdict.
module tb_sparse_polynomial_adder_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_TERMS    = spa_pkg::MAX_TERMS_DEF;
   localparam int COEFF_BITS   = spa_pkg::COEFF_BITS_DEF;
   localparam int EB           = spa_pkg::EXP_BITS;
   localparam int RESET_CYCLES = 9;
   localparam int RANDOM_ITEMS = 325;
   localparam int HOLD_CYCLES  = 400;
   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 200;
   localparam int FILL_TERMS   = MAX_TERMS + 4;
   localparam int FILL_SPACING = 65536 / FILL_TERMS;

   // Exponent ranges for random loads.
   localparam int EXP_NARROW = 0;
   localparam int EXP_EDGE   = 1;
   localparam int EXP_WIDE   = 2;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   spa_pkg::req_beat_type req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   spa_pkg::rsp_beat_type rsp_data;
   int                    outstanding;
   int                    mismatches;
   int                    items_sent = 0;
   int                    hold_seq = 0;
   int                    idle_cycles = 0;
   bit                    calm_sender = 1'b0;

   sparse_polynomial_adder_core #(
      .MAX_TERMS (MAX_TERMS),
      .COEFF_BITS(COEFF_BITS)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   sparse_polynomial_adder_checker #(
      .MAX_TERMS (MAX_TERMS),
      .COEFF_BITS(COEFF_BITS)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .outstanding(outstanding),
      .mismatches (mismatches)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: ends the run when nothing is accepted for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("sparse_polynomial_adder_core: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offers one request beat after a random gap and waits until it is accepted.
   task automatic send_beat(input logic kind, input logic sel, input logic [31:0] coeff,
                            input logic [EB-1:0] expo);
      int gap;
      int r;
      r = $urandom_range(0, 99);
      if (calm_sender || r < 60) gap = 0;
      else if (r < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 40);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{req_type: kind, which_poly: sel, term_coeff: coeff, term_exponent: expo};
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Drops valid and waits until every predicted result beat has arrived.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_coeff();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'hFFFF_FFFF;
         3: return $urandom_range(0, 6) - 3;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [EB-1:0] pick_expo(input int mode);
      if (mode == EXP_NARROW) return EB'($urandom_range(0, 7));
      if (mode == EXP_EDGE) begin
         case ($urandom_range(0, 4))
            0: return '0;
            1: return EB'(1);
            2: return '1 - EB'(1);
            3: return '1;
            default: return EB'($urandom());
         endcase
      end
      return EB'($urandom());
   endfunction

   // Hand-picked beats: empty sum, wrap, head combine, cancellation, zero terms.
   task automatic run_directed();
      send_beat(spa_pkg::REQ_ADD, spa_pkg::POLY_SECOND, 32'h0, 16'h0);
      send_beat(spa_pkg::REQ_LOAD, spa_pkg::POLY_FIRST, 32'd5, 16'd10);
      send_beat(spa_pkg::REQ_LOAD, spa_pkg::POLY_FIRST, 32'd3, 16'd10);
      send_beat(spa_pkg::REQ_LOAD, spa_pkg::POLY_FIRST, 32'h7FFF_FFFF, 16'hFFFF);
      send_beat(spa_pkg::REQ_LOAD, spa_pkg::POLY_FIRST, 32'd1, 16'hFFFF);
      send_beat(spa_pkg::REQ_LOAD, spa_pkg::POLY_FIRST, 32'd7, 16'd0);
      send_beat(spa_pkg::REQ_LOAD, spa_pkg::POLY_FIRST, -32'sd7, 16'd0);
      send_beat(spa_pkg::REQ_LOAD, spa_pkg::POLY_SECOND, -32'sd8, 16'd10);
      send_beat(spa_pkg::REQ_LOAD, spa_pkg::POLY_SECOND, 32'h8000_0000, 16'd20);
      send_beat(spa_pkg::REQ_LOAD, spa_pkg::POLY_SECOND, 32'hFFFF_FFFF, 16'd3);
      send_beat(spa_pkg::REQ_ADD, spa_pkg::POLY_FIRST, 32'hFFFF_FFFF, 16'hFFFF);
      // Everything cancels, so only the empty marker comes back.
      send_beat(spa_pkg::REQ_LOAD, spa_pkg::POLY_SECOND, 32'd4, 16'd5);
      send_beat(spa_pkg::REQ_LOAD, spa_pkg::POLY_FIRST, -32'sd4, 16'd5);
      send_beat(spa_pkg::REQ_ADD, spa_pkg::POLY_FIRST, 32'h0, 16'h0);
      // A loaded zero coefficient is still a term.
      send_beat(spa_pkg::REQ_LOAD, spa_pkg::POLY_SECOND, 32'd0, 16'd0);
      send_beat(spa_pkg::REQ_ADD, spa_pkg::POLY_SECOND, 32'h0, 16'h0);
      // Insertion at head and middle; a store term that wraps to zero then meets a one.
      send_beat(spa_pkg::REQ_LOAD, spa_pkg::POLY_FIRST, 32'd1, 16'd1);
      send_beat(spa_pkg::REQ_LOAD, spa_pkg::POLY_FIRST, 32'd3, 16'd3);
      send_beat(spa_pkg::REQ_LOAD, spa_pkg::POLY_FIRST, 32'd2, 16'd2);
      send_beat(spa_pkg::REQ_LOAD, spa_pkg::POLY_SECOND, 32'h8000_0000, 16'd1);
      send_beat(spa_pkg::REQ_LOAD, spa_pkg::POLY_SECOND, 32'h8000_0000, 16'd1);
      send_beat(spa_pkg::REQ_LOAD, spa_pkg::POLY_SECOND, 32'h0000_FFFF, 16'hFFFF);
      send_beat(spa_pkg::REQ_ADD, spa_pkg::POLY_SECOND, 32'h0, 16'h0);
   endtask

   // One load sequence and its add; some sequences overfill a store.
   task automatic run_sequence(input bit force_fill);
      int            mode;
      int            n;
      int            k;
      int            j;
      int            tmp;
      int            slots [FILL_TERMS];
      logic [EB-1:0] fill_expo [FILL_TERMS];
      logic [EB-1:0] e;
      logic [31:0]   c;
      logic          sel;
      calm_sender = ($urandom_range(0, 3) == 0);
      mode = $urandom_range(EXP_NARROW, EXP_WIDE);
      if (force_fill || $urandom_range(0, 7) == 0) begin
         // Distinct exponents in shuffled order run past the store's capacity.
         for (k = 0; k < FILL_TERMS; k++) slots[k] = k;
         for (k = FILL_TERMS - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp = slots[k];
            slots[k] = slots[j];
            slots[j] = tmp;
         end
         sel = 1'($urandom_range(0, 1));
         n = $urandom_range(MAX_TERMS + 1, FILL_TERMS);
         for (k = 0; k < n; k++) begin
            fill_expo[k] = EB'(slots[k] * FILL_SPACING + $urandom_range(0, FILL_SPACING - 1));
            send_beat(spa_pkg::REQ_LOAD, sel, pick_coeff(), fill_expo[k]);
         end
         // A combining load into the full store still lands.
         send_beat(spa_pkg::REQ_LOAD, sel, pick_coeff(),
                   fill_expo[$urandom_range(0, MAX_TERMS - 1)]);
         repeat ($urandom_range(0, 3))
            send_beat(spa_pkg::REQ_LOAD, ~sel, pick_coeff(), pick_expo(mode));
      end else begin
         n = $urandom_range(0, 10);
         repeat (n) begin
            e = pick_expo(mode);
            c = pick_coeff();
            sel = 1'($urandom_range(0, 1));
            send_beat(spa_pkg::REQ_LOAD, sel, c, e);
            // Sometimes follow with the negated term, into either store, so that it may cancel.
            if ($urandom_range(0, 4) == 0)
               send_beat(spa_pkg::REQ_LOAD, 1'($urandom_range(0, 1)), -c, e);
         end
      end
      send_beat(spa_pkg::REQ_ADD, 1'($urandom_range(0, 1)), $urandom(), EB'($urandom()));
      // Occasional add on empty stores.
      if ($urandom_range(0, 9) == 0)
         send_beat(spa_pkg::REQ_ADD, 1'($urandom_range(0, 1)), $urandom(), EB'($urandom()));
   endtask

   // Result side: short stalls, calm stretches, and long holds on request.
   initial begin
      int seen;
      int r;
      seen = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_seq != seen) begin
            seen = hold_seq;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
               rsp_ready <= 1'b1;
               repeat ($urandom_range(30, 80)) @(posedge clock);
            end else if (r < 65) begin
               rsp_ready <= 1'b1;
               @(posedge clock);
            end else if (r < 95) begin
               rsp_ready <= 1'b0;
               repeat ($urandom_range(1, 3)) @(posedge clock);
            end else begin
               rsp_ready <= 1'b0;
               repeat ($urandom_range(10, 30)) @(posedge clock);
            end
         end
      end
   end

   // Request side and verdict.
   initial begin
      int seq_index;
      int random_start;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      random_start = items_sent;
      seq_index = 0;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         if (seq_index == 3 || seq_index == 20) hold_seq <= hold_seq + 1;
         if (seq_index % 10 == 9) wait_for_results();
         run_sequence(seq_index == 1);
         seq_index++;
      end
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("sparse_polynomial_adder_core: match");
      end else begin
         $display("sparse_polynomial_adder_core: mismatch");
      end
      $finish;
   end

endmodule
